/* sv/fpp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpp_pkg
// Shared types, register indexes and the CRC-16/CCITT-FALSE byte update for
// the framed packet parser.
// ----------------------------------------------------------------------------
package fpp_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SOF_FIRST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SOF_SECOND = 1'b1;

	// Reset values of the start-of-frame markers
	localparam logic [7:0] SOF_FIRST_RST  = 8'hAA;
	localparam logic [7:0] SOF_SECOND_RST = 8'h55;

	// CRC-16/CCITT-FALSE
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	// Captured frame header, handed from the parser to the drain unit
	typedef struct packed {
		logic [7:0] dest;
		logic [7:0] src;
		logic [7:0] seq;
		logic [7:0] cmd;
		logic [6:0] len;
	} hdr_t;

	// Advance the CRC by one byte, MSB first, no reflection
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

/* sv/fpp_payload_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpp_payload_mem
// Payload byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fpp_payload_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem_q [DEPTH];

	// Write a captured payload byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read; hold the data between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* sv/fpp_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpp_parser
// Byte-level frame parser: start-of-frame hunt, header capture, payload
// write into the store, CRC accumulation and check. Holds the config regs.
// ----------------------------------------------------------------------------
module fpp_parser
	import fpp_pkg::*;
#(
	parameter int MAX_PAYLOAD = 64,
	parameter int AW          = 6
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 rx_fire,
	input  wire logic [7:0]           rx_byte,
	input  wire logic                 cfg_fire,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data,
	output logic                      wr_en,
	output logic      [AW-1:0]        wr_addr,
	output logic      [7:0]           wr_data,
	output logic                      start_q,
	output hdr_t                      hdr_q
);

	localparam logic [3:0] PH_SOF1 = 4'd0;
	localparam logic [3:0] PH_SOF2 = 4'd1;
	localparam logic [3:0] PH_DEST = 4'd2;
	localparam logic [3:0] PH_SRC  = 4'd3;
	localparam logic [3:0] PH_SEQ  = 4'd4;
	localparam logic [3:0] PH_CMD  = 4'd5;
	localparam logic [3:0] PH_LEN  = 4'd6;
	localparam logic [3:0] PH_DATA = 4'd7;
	localparam logic [3:0] PH_CRCL = 4'd8;
	localparam logic [3:0] PH_CRCH = 4'd9;

	logic [7:0]  sof_first_q;
	logic [7:0]  sof_second_q;
	logic [3:0]  phase_q;
	logic [6:0]  count_q;
	logic [15:0] crc_q;
	logic [7:0]  crc_low_q;
	logic [15:0] crc_nxt;
	logic [6:0]  count_nxt;
	logic [3:0]  hunt_phase;

	assign crc_nxt    = crc16_byte(crc_q, rx_byte);
	assign count_nxt  = count_q + 7'd1;
	assign hunt_phase = (rx_byte == sof_first_q) ? PH_SOF2 : PH_SOF1;

	// Store payload bytes as they arrive
	assign wr_en   = rx_fire && (phase_q == PH_DATA);
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = rx_byte;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sof_first_q  <= SOF_FIRST_RST;
			sof_second_q <= SOF_SECOND_RST;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_SOF_FIRST:  sof_first_q  <= cfg_data;
				REG_SOF_SECOND: sof_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Parser state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SOF1;
			count_q   <= '0;
			crc_q     <= CRC_INIT;
			crc_low_q <= '0;
			start_q   <= 1'b0;
			hdr_q     <= '0;
		end else begin
			start_q <= 1'b0;
			if (rx_fire) begin
				case (phase_q)
					PH_SOF1: begin
						phase_q <= hunt_phase;
					end
					PH_SOF2: begin
						crc_q   <= CRC_INIT;
						count_q <= '0;
						phase_q <= (rx_byte == sof_second_q) ? PH_DEST : hunt_phase;
					end
					PH_DEST: begin
						hdr_q.dest <= rx_byte;
						crc_q      <= crc_nxt;
						phase_q    <= PH_SRC;
					end
					PH_SRC: begin
						hdr_q.src <= rx_byte;
						crc_q     <= crc_nxt;
						phase_q   <= PH_SEQ;
					end
					PH_SEQ: begin
						hdr_q.seq <= rx_byte;
						crc_q     <= crc_nxt;
						phase_q   <= PH_CMD;
					end
					PH_CMD: begin
						hdr_q.cmd <= rx_byte;
						crc_q     <= crc_nxt;
						phase_q   <= PH_LEN;
					end
					PH_LEN: begin
						count_q <= '0;
						// Drop an oversize frame and hunt again
						if (rx_byte > 8'(MAX_PAYLOAD)) begin
							crc_q   <= CRC_INIT;
							phase_q <= hunt_phase;
						end else begin
							crc_q     <= crc_nxt;
							hdr_q.len <= rx_byte[6:0];
							phase_q   <= (rx_byte == 8'd0) ? PH_CRCL : PH_DATA;
						end
					end
					PH_DATA: begin
						count_q <= count_nxt;
						crc_q   <= crc_nxt;
						if (count_nxt >= hdr_q.len) begin
							phase_q <= PH_CRCL;
						end
					end
					PH_CRCL: begin
						crc_low_q <= rx_byte;
						phase_q   <= PH_CRCH;
					end
					PH_CRCH: begin
						count_q   <= '0;
						crc_q     <= CRC_INIT;
						crc_low_q <= '0;
						// Good CRC releases the frame; a bad one restarts the hunt
						if ({rx_byte, crc_low_q} == crc_q) begin
							start_q <= 1'b1;
							phase_q <= PH_SOF1;
						end else begin
							phase_q <= hunt_phase;
						end
					end
					default: begin
						phase_q   <= PH_SOF1;
						count_q   <= '0;
						crc_q     <= CRC_INIT;
						crc_low_q <= '0;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

/* sv/fpp_drain.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fpp_drain
// Walks the payload store after a good frame, one read per cycle while the output
// is not stalled, and presents one result per byte (a single result for an empty frame) through an output register.
// ----------------------------------------------------------------------------
module fpp_drain
	import fpp_pkg::*;
#(
	parameter int AW = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire hdr_t          hdr,
	output logic               rd_en,
	output logic     [AW-1:0]  rd_addr,
	input  wire logic [7:0]    rd_data,
	output logic               busy,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic     [7:0]     destination,
	output logic     [7:0]     source,
	output logic     [7:0]     sequence_res,
	output logic     [7:0]     command,
	output logic     [6:0]     frame_length,
	output logic               payload_present,
	output logic     [7:0]     payload_byte,
	output logic     [5:0]     payload_position,
	output logic               last
);

	logic       active_q;
	logic [6:0] idx_q;
	logic       valid_s1;
	logic       present_s1;
	logic       last_s1;
	logic [5:0] pos_s1;
	logic       move_s1;
	logic       issue;
	logic       is_last;
	logic       nonempty;

	assign nonempty = (hdr.len != 7'd0);
	assign is_last  = !nonempty || ((idx_q + 7'd1) == hdr.len);
	assign move_s1  = valid_s1 && (!out_valid || out_ready);
	assign issue    = active_q && (!valid_s1 || move_s1);

	assign rd_en   = issue && nonempty;
	assign rd_addr = idx_q[AW-1:0];
	assign busy    = active_q || valid_s1;

	// Read sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (issue) begin
			idx_q <= idx_q + 7'd1;
			if (is_last) begin
				active_q <= 1'b0;
			end
		end
	end

	// Read stage: waits for the store data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			present_s1 <= nonempty;
			last_s1    <= is_last;
			pos_s1     <= idx_q[5:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (move_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			destination      <= hdr.dest;
			source           <= hdr.src;
			sequence_res     <= hdr.seq;
			command          <= hdr.cmd;
			frame_length     <= hdr.len;
			payload_present  <= present_s1;
			payload_byte     <= present_s1 ? rd_data : 8'd0;
			payload_position <= pos_s1;
			last             <= last_s1;
		end
	end

endmodule
`default_nettype wire

/* sv/framed_packet_parser_crc16.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// framed_packet_parser_crc16
// Start-of-frame hunting packet parser with CRC-16/CCITT-FALSE check; good
// frames come out as one result per payload byte from the payload store (one result for an empty frame).
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  rx       in         rx_valid / rx_ready    rx_byte
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//  out      out        out_valid / out_ready  header fields, payload byte, last
//
//  A received byte is taken on each rx handshake; the parser never stalls while hunting
//  or capturing. After the CRC byte of a good frame, rx_ready drops while the
//  header is handed off, the store is read once per payload byte, and the last
//  read data moves into the output register. Output backpressure extends that stall.
//  Reset clears control state only; the payload store needs no clearing pass.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module framed_packet_parser_crc16
	import fpp_pkg::*;
#(
	parameter int MAX_PAYLOAD = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 rx_valid,
	output logic                      rx_ready,
	input  wire logic [7:0]           rx_byte,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [7:0]           destination,
	output logic      [7:0]           source,
	output logic      [7:0]           sequence_res,
	output logic      [7:0]           command,
	output logic      [6:0]           frame_length,
	output logic                      payload_present,
	output logic      [7:0]           payload_byte,
	output logic      [5:0]           payload_position,
	output logic                      last
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic          start;
	hdr_t          hdr;
	logic          busy;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          rx_fire;

	// Hold off new bytes while a frame is being read out of the store
	assign rx_ready  = !(start || busy);
	assign rx_fire   = rx_valid && rx_ready;
	assign cfg_ready = 1'b1;

	fpp_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.AW          (AW)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_fire   (rx_fire),
		.rx_byte   (rx_byte),
		.cfg_fire  (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.start_q   (start),
		.hdr_q     (hdr)
	);

	fpp_payload_mem #(
		.DEPTH (MAX_PAYLOAD),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	fpp_drain #(
		.AW (AW)
	) u_drain (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.hdr              (hdr),
		.rd_en            (rd_en),
		.rd_addr          (rd_addr),
		.rd_data          (rd_data),
		.busy             (busy),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.destination      (destination),
		.source           (source),
		.sequence_res     (sequence_res),
		.command          (command),
		.frame_length     (frame_length),
		.payload_present  (payload_present),
		.payload_byte     (payload_byte),
		.payload_position (payload_position),
		.last             (last)
	);

	// A new frame never starts while the previous one is still being read
	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy)
		else $error("frame start while drain busy");

	// The store is never written while it is being read out
	assert property (@(posedge clk) disable iff (!arst_n) wr_en |-> !busy && !start)
		else $error("payload write during drain");

	// An empty-frame result is always the only and last one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_present |-> last && frame_length == 7'd0)
		else $error("empty frame result malformed");

	// The last payload result sits at the final position of the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_present && last |-> payload_position == 6'(frame_length - 7'd1))
		else $error("last flag at wrong position");

endmodule
`default_nettype wire
